### sv/pcx_rle_decode_scatter_macros.svh
// Assertion macros for the PCX run-length decoder checker.
// Included by files that hold concurrent assertions; no other dependencies.
`ifndef PCX_RLE_DECODE_SCATTER_MACROS_SVH
`define PCX_RLE_DECODE_SCATTER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PCX_RDS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pcx_rds assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PCX_RDS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pcx_rds assertion failed");

`endif

### sv/pcx_rds_pkg.sv
// Shared types and constants of the PCX run-length decoder.
// No dependencies; imported by the datapath, controller, top level and checker.
`default_nettype none

package pcx_rds_pkg;

  localparam int unsigned ADDR_W  = 34;
  localparam int unsigned TOTAL_W = 35;
  localparam int unsigned IDX_W   = 4;

  localparam logic [7:0] RUN_MARK = 8'hC0;
  localparam logic [5:0] RUN_BITS = 6'h3F;

  localparam logic [IDX_W-1:0] CFG_WIDTH  = 4'd0;
  localparam logic [IDX_W-1:0] CFG_HEIGHT = 4'd1;
  localparam logic [IDX_W-1:0] CFG_LINE   = 4'd2;
  localparam logic [IDX_W-1:0] CFG_PLANES = 4'd3;

  typedef struct packed {
    logic [7:0] encoded_byte;
  } in_t;

  typedef struct packed {
    logic [7:0]        pixel_byte;
    logic [ADDR_W-1:0] dest_address;
    logic              last_of_run;
    logic              image_done;
  } out_t;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic [15:0]      value;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic calc_prod;
    logic calc_total;
    logic set_run;
    logic start_run;
    logic calc_row;
    logic step;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic complete;
    logic header;
    logic count_zero;
    logic emit;
    logic pend_valid;
    logic out_free;
    logic left_one;
  } sts_t;

endpackage

`default_nettype wire

### sv/pcx_rds_stream_if.sv
// Valid/ready channel carrying one payload per transaction.
// Payload type is a parameter; the block uses the structs of pcx_rds_pkg.
`default_nettype none

interface pcx_rds_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### sv/pcx_rds_datapath.sv
// Datapath of the PCX run-length decoder: registers, position counters,
// address arithmetic, result staging. Depends on pcx_rds_pkg.
`default_nettype none

module pcx_rds_datapath
  import pcx_rds_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire in_t  in_data_i,
  input  wire logic cfg_valid_i,
  input  wire cfg_t cfg_data_i,
  input  wire logic out_ready_i,
  output logic      out_valid_o,
  output out_t      out_data_o,
  input  wire cmd_t cmd_i,
  output sts_t      sts_o
);

  logic [15:0] width_q, height_q, line_q;
  logic [2:0]  planes_q;

  logic [7:0]         byte_q;
  logic [31:0]        prod_q;
  logic [TOTAL_W-1:0] total_q;

  logic               run_pending_q;
  logic [5:0]         run_length_q;
  logic [TOTAL_W-1:0] decoded_q;
  logic [15:0]        col_q, row_q;
  logic [2:0]         plane_q;

  logic [5:0]        left_q;
  logic              done_q;
  logic [ADDR_W-1:0] wf_q;

  logic              pend_valid_q;
  logic [7:0]        pend_byte_q;
  logic [ADDR_W-1:0] pend_addr_q;
  logic              pend_done_q;

  logic out_valid_q;
  out_t out_data_q;

  logic [5:0]         count;
  logic [TOTAL_W-1:0] remain, count_ext;
  logic [5:0]         clipped;
  logic               done_d;
  logic               scatter, emit;
  logic [16:0]        flip_u;
  logic signed [33:0] wf_s;
  logic [ADDR_W-1:0]  pos_sum, addr_mul, addr_sel;
  logic [15:0]        col_inc;
  logic [2:0]         plane_inc;
  logic               out_free;
  logic               out_load;

  assign count     = run_pending_q ? run_length_q : 6'd1;
  assign remain    = total_q - decoded_q;
  assign count_ext = TOTAL_W'(count);
  assign clipped   = (count_ext > remain) ? remain[5:0] : count;
  assign done_d    = (count != 6'd0) && (count_ext >= remain);

  assign scatter = (planes_q == 3'd3) || (planes_q == 3'd4);
  assign emit    = !scatter || (col_q < width_q);

  assign flip_u   = {1'b0, height_q} - 17'd1 - {1'b0, row_q};
  assign wf_s     = $signed(flip_u) * $signed({1'b0, width_q});
  assign pos_sum  = ADDR_W'(col_q) + wf_q;
  assign addr_mul = ADDR_W'(pos_sum * {31'd0, planes_q});
  assign addr_sel = scatter ? (addr_mul + ADDR_W'(plane_q)) : decoded_q[ADDR_W-1:0];

  assign col_inc   = col_q + 16'd1;
  assign plane_inc = plane_q + 3'd1;
  assign out_free  = !out_valid_q || out_ready_i;
  assign out_load  = cmd_i.flush || (cmd_i.step && emit && pend_valid_q);

  assign sts_o.complete   = decoded_q >= total_q;
  assign sts_o.header     = !run_pending_q && ((byte_q & RUN_MARK) == RUN_MARK);
  assign sts_o.count_zero = (count == 6'd0);
  assign sts_o.emit       = emit;
  assign sts_o.pend_valid = pend_valid_q;
  assign sts_o.out_free   = out_free;
  assign sts_o.left_one   = (left_q == 6'd1);

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q       <= 16'd1;
      height_q      <= 16'd1;
      line_q        <= 16'd1;
      planes_q      <= 3'd3;
      run_pending_q <= 1'b0;
      run_length_q  <= 6'd0;
      decoded_q     <= '0;
      col_q         <= '0;
      plane_q       <= '0;
      row_q         <= '0;
      pend_valid_q  <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_data_i.index)
          CFG_WIDTH:  width_q  <= cfg_data_i.value;
          CFG_HEIGHT: height_q <= cfg_data_i.value;
          CFG_LINE:   line_q   <= cfg_data_i.value;
          CFG_PLANES: planes_q <= cfg_data_i.value[2:0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      if (cmd_i.set_run) begin
        run_pending_q <= 1'b1;
        run_length_q  <= byte_q[5:0] & RUN_BITS;
      end

      if (cmd_i.start_run) begin
        run_pending_q <= 1'b0;
        run_length_q  <= 6'd0;
      end

      if (cmd_i.step) begin
        if (emit) begin
          pend_valid_q <= 1'b1;
        end
        decoded_q <= decoded_q + TOTAL_W'(1);
        if (col_inc >= line_q) begin
          col_q <= '0;
          if (plane_inc >= planes_q) begin
            plane_q <= '0;
            row_q   <= row_q + 16'd1;
          end else begin
            plane_q <= plane_inc;
          end
        end else begin
          col_q <= col_inc;
        end
      end

      if (cmd_i.flush) begin
        pend_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      byte_q <= in_data_i.encoded_byte;
    end
    if (cmd_i.calc_prod) begin
      prod_q <= line_q * height_q;
    end
    if (cmd_i.calc_total) begin
      total_q <= TOTAL_W'(prod_q) * TOTAL_W'(planes_q);
    end
    if (cmd_i.start_run) begin
      left_q <= clipped;
      done_q <= done_d;
    end
    if (cmd_i.calc_row) begin
      wf_q <= ADDR_W'(wf_s);
    end
    if (cmd_i.step) begin
      left_q <= left_q - 6'd1;
      if (emit) begin
        pend_byte_q <= byte_q;
        pend_addr_q <= addr_sel;
        pend_done_q <= done_q;
        if (pend_valid_q) begin
          out_data_q <= '{pixel_byte: pend_byte_q, dest_address: pend_addr_q,
                          last_of_run: 1'b0, image_done: pend_done_q};
        end
      end
    end
    if (cmd_i.flush) begin
      out_data_q <= '{pixel_byte: pend_byte_q, dest_address: pend_addr_q,
                      last_of_run: 1'b1, image_done: pend_done_q};
    end
  end

endmodule

`default_nettype wire

### sv/pcx_rds_ctrl.sv
// Controller of the PCX run-length decoder: sequences one input byte
// through total, decision, per-byte address and flush. Depends on pcx_rds_pkg.
`default_nettype none

module pcx_rds_ctrl
  import pcx_rds_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROD,
    S_TOTAL,
    S_DECIDE,
    S_ROW,
    S_EMIT,
    S_FLUSH
  } state_e;

  state_e state_q, state_d;
  logic   stall;

  assign in_ready_o = (state_q == S_IDLE);
  assign stall      = sts_i.emit && sts_i.pend_valid && !sts_i.out_free;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_PROD;
        end
      end
      S_PROD: begin
        cmd_o.calc_prod = 1'b1;
        state_d         = S_TOTAL;
      end
      S_TOTAL: begin
        cmd_o.calc_total = 1'b1;
        state_d          = S_DECIDE;
      end
      S_DECIDE: begin
        priority if (sts_i.complete) begin
          state_d = S_IDLE;
        end else if (sts_i.header) begin
          cmd_o.set_run = 1'b1;
          state_d       = S_IDLE;
        end else begin
          cmd_o.start_run = 1'b1;
          state_d         = sts_i.count_zero ? S_IDLE : S_ROW;
        end
      end
      S_ROW: begin
        cmd_o.calc_row = 1'b1;
        state_d        = S_EMIT;
      end
      S_EMIT: begin
        if (!stall) begin
          cmd_o.step = 1'b1;
          state_d    = sts_i.left_one ? S_FLUSH : S_ROW;
        end
      end
      S_FLUSH: begin
        priority if (!sts_i.pend_valid) begin
          state_d = S_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### sv/pcx_rle_decode_scatter.sv
// Top level of the PCX run-length decoder with address scatter.
// Depends on pcx_rds_pkg, pcx_rds_stream_if, pcx_rds_ctrl, pcx_rds_datapath.
//
// Channels: cfg_i writes one register per transaction (0 width, 1 height,
// 2 line bytes, 3 plane count) and is always ready; write it only while idle.
// in_i takes one encoded byte per transaction; out_o gives one decoded byte
// with its buffer address, last-of-run and image-done flags per transaction.
// Sequence: a byte is taken only in the idle state. A run header, a zero run or
// a byte after image completion passes through the total product and the
// decision only. A byte that decodes to n bytes passes through the total
// product, the decision, then one address multiply and one address/position
// step per decoded byte, then a flush. The last result of a byte leaves
// through a one-entry holding register so that trailing padding can be
// skipped before last_of_run is known.
// Reset clears the position counters, pending run and both result
// registers, and loads width 1, height 1, line bytes 1, three planes.
// A stalled receiver holds out_o stable; decoding stops when the holding
// register and the output register are both full, and resumes when out_o
// completes a transaction.
`default_nettype none

module pcx_rle_decode_scatter
  import pcx_rds_pkg::*;
(
  input wire logic          clk_i,
  input wire logic          rst_ni,
  pcx_rds_stream_if.sink   cfg_i,
  pcx_rds_stream_if.sink   in_i,
  pcx_rds_stream_if.source out_o
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_i.ready = 1'b1;

  pcx_rds_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pcx_rds_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_i.data),
    .cfg_valid_i (cfg_i.valid),
    .cfg_data_i  (cfg_i.data),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_data_o  (out_o.data),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

`default_nettype wire

### sv/pcx_rds_checker.sv
// Port-level assertions for pcx_rle_decode_scatter, bound to the top level.
// Depends on pcx_rds_pkg and pcx_rle_decode_scatter_macros.svh.
`default_nettype none
`include "pcx_rle_decode_scatter_macros.svh"

module pcx_rds_checker
  import pcx_rds_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_i,
  input wire logic out_valid_i,
  input wire logic out_ready_i,
  input wire out_t out_data_i
);

  `PCX_RDS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_data_i))

  `PCX_RDS_ASSERT_NEXT(a_one_byte_at_a_time, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)

  `PCX_RDS_ASSERT_NEXT(a_done_is_final, clk_i, rst_ni, out_valid_i && out_ready_i && out_data_i.image_done && out_data_i.last_of_run, !out_valid_i)

endmodule

bind pcx_rle_decode_scatter pcx_rds_checker u_pcx_rds_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

`default_nettype wire
